[rtl/cidr_prefix_trie_filter_assert.svh]
// assertion macros used by the trie filter engine rtl
// no dependencies; the macros expand to nothing when NO_ASSERTIONS is set
`ifndef CIDR_PREFIX_TRIE_FILTER_ASSERT_SVH
`define CIDR_PREFIX_TRIE_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CPTF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cptf assertion failed");
`define CPTF_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("cptf forbidden condition seen");
`else
`define CPTF_ASSERT(lbl, clk, rst_n, prop)
`define CPTF_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/cptf_pkg.sv]
// shared types and constants of the cidr prefix trie filter
// no dependencies
package cptf_pkg;

    localparam int NODE_COUNT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0]  PLEN_MAX = 8'd128;
    localparam logic [7:0]  V4_START = 8'd96;
    localparam logic [7:0]  V6_START = 8'd0;
    localparam logic [7:0]  TOP_BIT  = 8'd127;
    localparam logic [31:0] V4_TAG   = 32'h0000_ffff;

    localparam logic [1:0] LEAF_NONE   = 2'b00;
    localparam logic [1:0] LEAF_PERMIT = 2'b01;
    localparam logic [1:0] LEAF_REJECT = 2'b10;
    localparam logic [1:0] LEAF_BOTH   = 2'b11;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ALLOW  = 2'd1,
        OP_DENY   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RESP_NONE  = 2'd0,
        RESP_ALLOW = 2'd1,
        RESP_DENY  = 2'd2,
        RESP_ERROR = 2'd3
    } resp_t;

    typedef struct packed {
        op_t          op;
        logic [127:0] addr;
        logic [7:0]   plen;
        logic         is_v4;
    } cmd_t;

endpackage

[rtl/cptf_in_if.sv]
// request channel of the trie filter: operation, address and prefix length
// no dependencies
interface cptf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;

    modport source (output valid, op, addr_hi, addr_lo, prefix_len, input ready);
    modport sink   (input valid, op, addr_hi, addr_lo, prefix_len, output ready);
endinterface

[rtl/cptf_out_if.sv]
// response channel of the trie filter
// no dependencies
interface cptf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] response;

    modport source (output valid, response, input ready);
    modport sink   (input valid, response, output ready);
endinterface

[rtl/cptf_front.sv]
// front end: accepts request items and classifies them into commands
// depends on cptf_pkg and cptf_in_if
module cptf_front (
    cptf_in_if.sink         req,
    output cptf_pkg::cmd_t  cmd,
    output logic            push,
    input  logic            full
);
    import cptf_pkg::*;

    logic       v4;
    logic [7:0] plen;

    // ipv4-mapped form ::ffff:a.b.c.d
    assign v4   = (req.addr_hi == 64'd0) && (req.addr_lo[63:32] == V4_TAG);
    assign plen = (req.prefix_len > PLEN_MAX) ? PLEN_MAX : req.prefix_len;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    assign cmd.op    = op_t'(req.op);
    assign cmd.addr  = {req.addr_hi, req.addr_lo};
    assign cmd.plen  = plen;
    assign cmd.is_v4 = v4;
endmodule

[rtl/cptf_fifo.sv]
// short command queue between front end and trie engine
// depends on cptf_pkg
module cptf_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cptf_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output cptf_pkg::cmd_t  dout,
    output logic            empty
);
    import cptf_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [PW:0]   CNT_FULL = (PW + 1)'(QUEUE_DEPTH);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

[rtl/cptf_engine.sv]
// trie engine: node memory, free list and the walk sequencer
// depends on cptf_pkg, cptf_out_if and cidr_prefix_trie_filter_assert.svh
`include "cidr_prefix_trie_filter_assert.svh"
module cptf_engine #(
    parameter int NODE_COUNT = cptf_pkg::NODE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cptf_pkg::cmd_t  cmd,
    input  logic            empty,
    output logic            pop,
    cptf_out_if.source      rsp
);
    import cptf_pkg::*;

    localparam int LW = $clog2(NODE_COUNT);

    typedef logic [LW-1:0] link_t;
    typedef struct packed {
        logic [1:0] leaf;
        link_t      link;
    } child_t;
    typedef struct packed {
        child_t c1;
        child_t c0;
    } node_t;

    localparam link_t ROOT_V4    = LW'(1);
    localparam link_t ROOT_V6    = LW'(2);
    localparam link_t FIRST_FREE = LW'(3);
    localparam link_t LAST_NODE  = LW'(NODE_COUNT - 1);

    typedef enum logic [18:0] {
        ST_CLR      = 19'd1 << 0,
        ST_IDLE     = 19'd1 << 1,
        ST_LK_RD    = 19'd1 << 2,
        ST_LK_USE   = 19'd1 << 3,
        ST_IN_RD    = 19'd1 << 4,
        ST_IN_USE   = 19'd1 << 5,
        ST_TK_RD    = 19'd1 << 6,
        ST_TK_USE   = 19'd1 << 7,
        ST_TW_RD    = 19'd1 << 8,
        ST_TW_USE   = 19'd1 << 9,
        ST_LINK     = 19'd1 << 10,
        ST_INIT     = 19'd1 << 11,
        ST_GB_START = 19'd1 << 12,
        ST_GB_RD    = 19'd1 << 13,
        ST_GB_USE   = 19'd1 << 14,
        ST_ROOT_RD  = 19'd1 << 15,
        ST_ROOT_USE = 19'd1 << 16,
        ST_FIN      = 19'd1 << 17,
        ST_DONE     = 19'd1 << 18
    } state_t;

    typedef enum logic [1:0] {
        RET_ROOT1 = 2'd0,
        RET_ROOT2 = 2'd1,
        RET_LEAF  = 2'd2
    } ret_t;

    // node memory
    node_t mem [NODE_COUNT];
    node_t mem_q;
    logic  rd_en;
    link_t rd_addr;
    logic  we;
    link_t wr_addr;
    node_t wr_data;

    state_t     state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    link_t      n_reg, n_next;
    logic [7:0] b_reg, b_next;
    logic [1:0] inherit_reg, inherit_next;
    node_t      node_reg, node_next;
    logic       v_reg, v_next;
    link_t      fh_reg, fh_next;
    link_t      h_reg, h_next;
    link_t      m_reg, m_next;
    child_t     w1_reg, w1_next;
    link_t      gb_id_reg, gb_id_next;
    ret_t       ret_reg, ret_next;
    link_t      clr_cnt_reg, clr_cnt_next;
    logic       clr_resp_reg, clr_resp_next;
    resp_t      resp_reg, resp_next;
    logic       out_valid_reg, out_valid_next;
    resp_t      out_resp_reg, out_resp_next;

    logic       cur_bit;
    logic [1:0] rule;
    logic [7:0] last;
    child_t     sel_q;
    child_t     sel_node;
    child_t     rule_child;
    logic       fh_is_root;

    assign cur_bit    = cmd_reg.addr[7'(TOP_BIT - b_reg)];
    assign rule       = (cmd_reg.op == OP_ALLOW) ? LEAF_PERMIT : LEAF_REJECT;
    assign last       = cmd_reg.plen - 8'd1;
    assign sel_q      = cur_bit ? mem_q.c1 : mem_q.c0;
    assign sel_node   = v_reg ? node_reg.c1 : node_reg.c0;
    assign rule_child = '{leaf: rule, link: '0};
    assign fh_is_root = (fh_reg == ROOT_V4) || (fh_reg == ROOT_V6);

    assign rsp.valid    = out_valid_reg;
    assign rsp.response = out_resp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        b_next         = b_reg;
        inherit_next   = inherit_reg;
        node_next      = node_reg;
        v_next         = v_reg;
        fh_next        = fh_reg;
        h_next         = h_reg;
        m_next         = m_reg;
        w1_next        = w1_reg;
        gb_id_next     = gb_id_reg;
        ret_next       = ret_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_resp_next  = clr_resp_reg;
        resp_next      = resp_reg;
        out_valid_next = out_valid_reg;
        out_resp_next  = out_resp_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = n_reg;
        we             = 1'b0;
        wr_addr        = n_reg;
        wr_data        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                we      = 1'b1;
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg >= FIRST_FREE && clr_cnt_reg < LAST_NODE)
                begin
                    wr_data.c0.link = clr_cnt_reg + 1'b1;
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_NODE)
                begin
                    fh_next    = FIRST_FREE;
                    resp_next  = RESP_NONE;
                    state_next = clr_resp_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop          = 1'b1;
                    cmd_next     = cmd;
                    n_next       = cmd.is_v4 ? ROOT_V4 : ROOT_V6;
                    b_next       = cmd.is_v4 ? V4_START : V6_START;
                    inherit_next = LEAF_NONE;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                            state_next    = ST_CLR;
                        end
                        OP_LOOKUP:
                        begin
                            state_next = ST_LK_RD;
                        end
                        default:
                        begin
                            if (cmd.plen <= (cmd.is_v4 ? V4_START : V6_START))
                            begin
                                state_next = ST_ROOT_RD;
                            end
                            else
                            begin
                                state_next = ST_IN_RD;
                            end
                        end
                    endcase
                end
            end
            ST_LK_RD:
            begin
                if (b_reg >= cmd_reg.plen)
                begin
                    resp_next  = RESP_NONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_LK_USE;
                end
            end
            ST_LK_USE:
            begin
                if (sel_q.leaf != LEAF_NONE)
                begin
                    resp_next  = resp_t'(sel_q.leaf);
                    state_next = ST_DONE;
                end
                else if (sel_q.link == '0)
                begin
                    resp_next  = RESP_NONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    n_next     = sel_q.link;
                    b_next     = b_reg + 8'd1;
                    state_next = ST_LK_RD;
                end
            end
            ST_IN_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_IN_USE;
            end
            ST_IN_USE:
            begin
                node_next = mem_q;
                v_next    = cur_bit;
                if (b_reg == last)
                begin
                    // final bit: free what hangs below and place the rule
                    gb_id_next = sel_q.link;
                    ret_next   = RET_LEAF;
                    state_next = ST_GB_START;
                end
                else if (sel_q.link != '0)
                begin
                    n_next     = sel_q.link;
                    b_next     = b_reg + 8'd1;
                    state_next = ST_IN_RD;
                end
                else if ((sel_q.leaf & rule) != LEAF_NONE)
                begin
                    resp_next  = resp_t'(rule);
                    state_next = ST_DONE;
                end
                else
                begin
                    if (inherit_reg == LEAF_NONE)
                    begin
                        inherit_next = sel_q.leaf;
                    end
                    h_next = fh_reg;
                    if (fh_reg == '0)
                    begin
                        resp_next  = RESP_ERROR;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_TK_RD;
                    end
                end
            end
            ST_TK_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = h_reg;
                state_next = ST_TK_USE;
            end
            ST_TK_USE:
            begin
                if (mem_q.c0.link != '0)
                begin
                    fh_next = mem_q.c0.link;
                    if (mem_q.c1.link != '0)
                    begin
                        // splice the freed side chain onto the tail of child 1 links
                        m_next     = mem_q.c0.link;
                        w1_next    = mem_q.c1;
                        state_next = ST_TW_RD;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    fh_next    = mem_q.c1.link;
                    state_next = ST_LINK;
                end
            end
            ST_TW_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = m_reg;
                state_next = ST_TW_USE;
            end
            ST_TW_USE:
            begin
                if (mem_q.c1.link != '0)
                begin
                    m_next     = mem_q.c1.link;
                    state_next = ST_TW_RD;
                end
                else
                begin
                    we         = 1'b1;
                    wr_addr    = m_reg;
                    wr_data    = '{c1: w1_reg, c0: mem_q.c0};
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                we      = 1'b1;
                wr_addr = n_reg;
                wr_data = node_reg;
                if (v_reg)
                begin
                    wr_data.c1 = '{leaf: LEAF_NONE, link: h_reg};
                end
                else
                begin
                    wr_data.c0 = '{leaf: LEAF_NONE, link: h_reg};
                end
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                we         = 1'b1;
                wr_addr    = h_reg;
                wr_data    = '{c1: '{leaf: inherit_reg, link: '0},
                               c0: '{leaf: inherit_reg, link: '0}};
                n_next     = h_reg;
                b_next     = b_reg + 8'd1;
                state_next = ST_IN_RD;
            end
            ST_GB_START:
            begin
                m_next     = gb_id_reg;
                state_next = (gb_id_reg == '0) ? ST_FIN : ST_GB_RD;
            end
            ST_GB_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = m_reg;
                state_next = ST_GB_USE;
            end
            ST_GB_USE:
            begin
                if (mem_q.c0.link != '0)
                begin
                    m_next     = mem_q.c0.link;
                    state_next = ST_GB_RD;
                end
                else
                begin
                    we         = 1'b1;
                    wr_addr    = m_reg;
                    wr_data.c1 = mem_q.c1;
                    wr_data.c0.leaf = (mem_q.c0.leaf != LEAF_NONE) ? mem_q.c0.leaf
                                                                   : LEAF_BOTH;
                    wr_data.c0.link = fh_reg;
                    fh_next    = gb_id_reg;
                    state_next = ST_FIN;
                end
            end
            ST_ROOT_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_ROOT_USE;
            end
            ST_ROOT_USE:
            begin
                node_next  = mem_q;
                gb_id_next = mem_q.c0.link;
                ret_next   = RET_ROOT1;
                state_next = ST_GB_START;
            end
            ST_FIN:
            begin
                case (ret_reg)
                    RET_ROOT1:
                    begin
                        gb_id_next = node_reg.c1.link;
                        ret_next   = RET_ROOT2;
                        state_next = ST_GB_START;
                    end
                    RET_ROOT2:
                    begin
                        we         = 1'b1;
                        wr_data    = '{c1: rule_child, c0: rule_child};
                        resp_next  = RESP_NONE;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        if ((sel_node.leaf & rule) != LEAF_NONE)
                        begin
                            resp_next = resp_t'(rule);
                        end
                        else
                        begin
                            we      = 1'b1;
                            wr_data = node_reg;
                            if (v_reg)
                            begin
                                wr_data.c1 = rule_child;
                            end
                            else
                            begin
                                wr_data.c0 = rule_child;
                            end
                            resp_next = RESP_NONE;
                        end
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_resp_next  = resp_reg;
                    clr_resp_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            fh_reg        <= FIRST_FREE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_resp_reg  <= clr_resp_next;
            fh_reg        <= fh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        n_reg        <= n_next;
        b_reg        <= b_next;
        inherit_reg  <= inherit_next;
        node_reg     <= node_next;
        v_reg        <= v_next;
        h_reg        <= h_next;
        m_reg        <= m_next;
        w1_reg       <= w1_next;
        gb_id_reg    <= gb_id_next;
        ret_reg      <= ret_next;
        resp_reg     <= resp_next;
        out_resp_reg <= out_resp_next;
    end

    `CPTF_NEVER(a_free_head_root, clk, rst_n, (state_reg != ST_CLR) && fh_is_root)
    `CPTF_ASSERT(a_out_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    `CPTF_NEVER(a_link_null_node, clk, rst_n, (state_reg == ST_LINK) && (h_reg == '0))
    `CPTF_NEVER(a_pop_while_busy, clk, rst_n, pop && (state_reg != ST_IDLE))
endmodule

[rtl/cidr_prefix_trie_filter.sv]
// cidr allow/deny filter: front end, command queue and trie engine with node memory
// work per item: a lookup reads a node per trie level walked; an insert reads a node per level,
//   and also grows nodes from the free list and walks free-list chains
// throughput: one item at a time through the engine; the queue takes up to 2 more meanwhile
// reset and clear: a sweep over every node rebuilds the free chain, no item is started meanwhile
module cidr_prefix_trie_filter #(
    parameter int NODE_COUNT = cptf_pkg::NODE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cptf_in_if.sink     req,
    cptf_out_if.source  rsp
);
    import cptf_pkg::*;

    // classified command from the front end
    cmd_t front_cmd;
    logic front_push;
    logic queue_full;

    // head of the queue towards the engine
    cmd_t queue_cmd;
    logic queue_empty;
    logic engine_pop;

    // front end classifies ipv4-mapped against ipv6 and saturates the prefix
    cptf_front u_front (
        .req  (req),
        .cmd  (front_cmd),
        .push (front_push),
        .full (queue_full)
    );

    // short queue so the requester is not held while the engine walks, unless the queue is full
    cptf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .full  (queue_full),
        .pop   (engine_pop),
        .dout  (queue_cmd),
        .empty (queue_empty)
    );

    // engine owns the node memory, the free list and the output register
    cptf_engine #(
        .NODE_COUNT (NODE_COUNT)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (queue_cmd),
        .empty (queue_empty),
        .pop   (engine_pop),
        .rsp   (rsp)
    );
endmodule
